/* sv/ccq_pkg.sv */
// Shared types and constants of the coalescing command queue.
package ccq_pkg;

    // Widths of the message fields and of the configuration index
    localparam int DATA_W  = 32;
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DROPPED       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED_REPLY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POPPED        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY         = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_OFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_VOLUME = 3'd4;

    // Fields that decide a conflict
    typedef struct packed {
        logic [DATA_W-1:0] device;
        logic [DATA_W-1:0] msg_class;
        logic [DATA_W-1:0] command;
    } msg_key_t;

    // One queue entry as stored in memory
    typedef struct packed {
        msg_key_t         key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Coalescing configuration
    typedef struct packed {
        logic [DATA_W-1:0] class_code;
        logic [DATA_W-1:0] group_on;
        logic [DATA_W-1:0] group_off;
        logic [DATA_W-1:0] group_level;
        logic [DATA_W-1:0] group_volume;
    } cfg_t;

endpackage

/* sv/ccq_mem.sv */
// Entry memory: one write port, one read port with registered read data.
module ccq_mem #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  ccq_pkg::entry_t               wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output ccq_pkg::entry_t               rd_data
);

    ccq_pkg::entry_t mem_array [DEPTH];
    ccq_pkg::entry_t rd_data_reg;

    // Synchronous write and read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ccq_match.sv */
// Conflict check between a stored entry and the message being pushed.
module ccq_match (
    input  ccq_pkg::msg_key_t stored,
    input  ccq_pkg::msg_key_t incoming,
    input  ccq_pkg::cfg_t     cfg,
    output logic              conflict
);

    logic both_cmd;
    logic same_id;
    logic stored_grp;
    logic incoming_grp;

    // Both must target the same device and carry the command class
    assign both_cmd = (stored.device == incoming.device)
                   && (stored.msg_class == cfg.class_code)
                   && (incoming.msg_class == cfg.class_code);

    assign same_id = (stored.command == incoming.command);

    // Membership in the on/off/level/volume group
    assign stored_grp = (stored.command == cfg.group_on)
                     || (stored.command == cfg.group_off)
                     || (stored.command == cfg.group_level)
                     || (stored.command == cfg.group_volume);

    assign incoming_grp = (incoming.command == cfg.group_on)
                       || (incoming.command == cfg.group_off)
                       || (incoming.command == cfg.group_level)
                       || (incoming.command == cfg.group_volume);

    assign conflict = both_cmd && (same_id || (stored_grp && incoming_grp));

endmodule

/* sv/coalescing_command_queue.sv */
// Coalescing command queue: head-pointer FIFO in a synchronous RAM with compaction.
// Refusals, empty pops and pushes to an empty queue: result in the cycle after start;
// a pop answers from S_POP. A push to queued entries scans them in order up to a drop,
// then shifts the later entries down; the accepted result follows the append.
// busy drops as the final result shows, so the next transaction can start then; results
// are one-cycle strobes on result_valid that cannot stall. Async reset empties the queue.
module coalescing_command_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [ccq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccq_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic                              op,
    input  logic [ccq_pkg::DATA_W-1:0]        dest_device,
    input  logic [ccq_pkg::DATA_W-1:0]        message_class,
    input  logic [ccq_pkg::DATA_W-1:0]        command_id,
    input  logic                              needs_reply,
    input  logic [ccq_pkg::TAG_W-1:0]         msg_handle,
    output logic                              result_valid,
    output logic [ccq_pkg::KIND_W-1:0]        out_kind,
    output logic [ccq_pkg::TAG_W-1:0]         out_handle,
    output logic [ccq_pkg::DATA_W-1:0]        out_device,
    output logic [ccq_pkg::DATA_W-1:0]        out_class,
    output logic [ccq_pkg::DATA_W-1:0]        out_command,
    output logic                              last
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POP   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    ccq_pkg::entry_t         new_reg, new_next;
    ccq_pkg::cfg_t           cfg_reg, cfg_next;

    logic                    valid_reg, valid_next;
    logic [ccq_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [ccq_pkg::TAG_W-1:0]  handle_reg, handle_next;
    logic [ccq_pkg::DATA_W-1:0] device_reg, device_next;
    logic [ccq_pkg::DATA_W-1:0] class_reg, class_next;
    logic [ccq_pkg::DATA_W-1:0] command_reg, command_next;
    logic                    last_reg, last_next;

    logic                    wr_en;
    logic [PW-1:0]           wr_addr;
    ccq_pkg::entry_t         wr_data;
    logic [PW-1:0]           rd_addr;
    ccq_pkg::entry_t         rd_data;
    logic                    conflict;
    logic                    accept;
    ccq_pkg::entry_t         in_entry;

    // Logical position from head to physical RAM address
    function automatic logic [PW-1:0] to_phys(input logic [PW-1:0] head,
                                               input logic [SW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + pos;
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    ccq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ccq_match u_match (
        .stored   (rd_data.key),
        .incoming (new_reg.key),
        .cfg      (cfg_reg),
        .conflict (conflict)
    );

    assign accept = start && (state_reg == S_IDLE);

    assign in_entry.key.device    = dest_device;
    assign in_entry.key.msg_class = message_class;
    assign in_entry.key.command   = command_id;
    assign in_entry.tag           = msg_handle;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ccq_pkg::CFG_CLASS_CODE:   cfg_next.class_code   = cfg_wdata;
                ccq_pkg::CFG_GROUP_ON:     cfg_next.group_on     = cfg_wdata;
                ccq_pkg::CFG_GROUP_OFF:    cfg_next.group_off    = cfg_wdata;
                ccq_pkg::CFG_GROUP_LEVEL:  cfg_next.group_level  = cfg_wdata;
                ccq_pkg::CFG_GROUP_VOLUME: cfg_next.group_volume = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Sequencer: refusals, pop, scan, shift-down and append
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        new_next     = new_reg;
        valid_next   = 1'b0;
        kind_next    = kind_reg;
        handle_next  = handle_reg;
        device_next  = '0;
        class_next   = '0;
        command_next = '0;
        last_next    = 1'b1;
        wr_en        = 1'b0;
        wr_addr      = to_phys(head_reg, SW'(count_reg));
        wr_data      = new_reg;
        rd_addr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op)
                    begin
                        if (count_reg == '0)
                        begin
                            valid_next  = 1'b1;
                            kind_next   = ccq_pkg::KIND_EMPTY;
                            handle_next = '0;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else if (needs_reply)
                    begin
                        valid_next  = 1'b1;
                        kind_next   = ccq_pkg::KIND_REFUSED_REPLY;
                        handle_next = msg_handle;
                    end
                    else if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        valid_next  = 1'b1;
                        kind_next   = ccq_pkg::KIND_REFUSED_FULL;
                        handle_next = msg_handle;
                    end
                    else if (count_reg == '0)
                    begin
                        // Nothing to scan: append at once
                        wr_en       = 1'b1;
                        wr_addr     = head_reg;
                        wr_data     = in_entry;
                        count_next  = count_reg + CW'(1);
                        valid_next  = 1'b1;
                        kind_next   = ccq_pkg::KIND_ACCEPTED;
                        handle_next = msg_handle;
                    end
                    else
                    begin
                        new_next   = in_entry;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_POP:
            begin
                valid_next   = 1'b1;
                kind_next    = ccq_pkg::KIND_POPPED;
                handle_next  = rd_data.tag;
                device_next  = rd_data.key.device;
                class_next   = rd_data.key.msg_class;
                command_next = rd_data.key.command;
                head_next    = to_phys(head_reg, SW'(1));
                count_next   = count_reg - CW'(1);
                state_next   = S_IDLE;
            end

            S_SCAN:
            begin
                // rd_data holds entry idx_reg; fetch the next one meanwhile
                rd_addr = to_phys(head_reg, SW'(idx_reg) + SW'(1));
                if (conflict)
                begin
                    valid_next  = 1'b1;
                    kind_next   = ccq_pkg::KIND_DROPPED;
                    handle_next = rd_data.tag;
                    last_next   = 1'b0;
                    state_next  = S_SHIFT;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CW'(1);
                    valid_next  = 1'b1;
                    kind_next   = ccq_pkg::KIND_ACCEPTED;
                    handle_next = new_reg.tag;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_SHIFT:
            begin
                // rd_data holds entry idx_reg+1; reads stay ahead of writes
                rd_addr = to_phys(head_reg, SW'(idx_reg) + SW'(2));
                wr_en   = 1'b1;
                wr_addr = to_phys(head_reg, SW'(idx_reg));
                if (idx_reg + CW'(1) < count_reg)
                begin
                    wr_data  = rd_data;
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    // Last slot freed by the drop takes the new message
                    wr_data     = new_reg;
                    valid_next  = 1'b1;
                    kind_next   = ccq_pkg::KIND_ACCEPTED;
                    handle_next = new_reg.tag;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            head_reg             <= '0;
            count_reg            <= '0;
            idx_reg              <= '0;
            valid_reg            <= 1'b0;
            cfg_reg.class_code   <= 32'd1;
            cfg_reg.group_on     <= '0;
            cfg_reg.group_off    <= '0;
            cfg_reg.group_level  <= '0;
            cfg_reg.group_volume <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            cfg_reg   <= cfg_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_reg     <= new_next;
        kind_reg    <= kind_next;
        handle_reg  <= handle_next;
        device_reg  <= device_next;
        class_reg   <= class_next;
        command_reg <= command_next;
        last_reg    <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign out_kind     = kind_reg;
    assign out_handle   = handle_reg;
    assign out_device   = device_reg;
    assign out_class    = class_reg;
    assign out_command  = command_reg;
    assign last         = last_reg;

endmodule
